// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
// Each macro names the clock, the reset and the message at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

  // Vertex table geometry
  localparam int MAX_VERTICES = 32;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 6;
  localparam int LAT_W        = 16;
  localparam int LON_W        = 17;
  localparam int PROD_W       = (LON_W + 1) + (LAT_W + 1);

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VERTICES);

  // Request action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;    // latch query point, clear inside flag
    logic              load;     // write request vertex into the table
    logic              rd_en;    // read one table entry
    logic              rd_edge;  // the read closes an edge (not the priming read)
    logic [VIDX_W-1:0] rd_addr;
    logic              publish;  // move inside flag into the output register
  } pip_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic             busy;      // edge pipeline still holds work
    logic             out_full;  // output register holds a result not taken
    logic [CNT_W-1:0] count;     // vertex count, saturated to the table size
  } pip_sts_t;

endpackage

// ===== rtl/core/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer of the point-in-polygon core: takes requests, walks the edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pip_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  pip_pkg::pip_sts_t  sts,
  output pip_pkg::pip_cmd_t  cmd
);
  import pip_pkg::*;

  pip_state_t        state, state_next;
  logic [VIDX_W-1:0] idx, idx_next;
  logic [VIDX_W-1:0] last_idx;

  assign last_idx = VIDX_W'(sts.count - CNT_W'(1));

  // State and edge index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.rd_addr = idx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            idx_next  = '0;
            if (sts.count == '0) begin
              state_next = ST_FINISH;
            end else begin
              state_next = ST_PRIME;
            end
          end
        end
      end
      ST_PRIME: begin
        // fetch the last vertex as the first edge's far end
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = last_idx;
        state_next  = ST_WALK;
      end
      ST_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_edge = 1'b1;
        if (idx == last_idx) begin
          state_next = ST_DRAIN;
        end else begin
          idx_next = idx + VIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!sts.out_full) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_SAME_CYCLE(a_idle_quiet, clk, rst, state == ST_IDLE, !sts.busy,
    "edge pipeline busy while idle")
  `ASSERT_SAME_CYCLE(a_walk_range, clk, rst, state == ST_WALK,
    {1'b0, idx} < sts.count, "edge index beyond vertex count")
  `ASSERT_NEXT_CYCLE(a_start_leaves, clk, rst, cmd.start, state != ST_IDLE,
    "query start did not leave idle")

endmodule

// ===== rtl/core/pip_dp.sv =====
// ----------------------------------------------------------------------------
// pip_dp
// Datapath of the point-in-polygon core: vertex table, edge test pipeline,
// count register and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pip_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pip_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic [pip_pkg::VIDX_W-1:0]        vertex_index,
  input  logic signed [pip_pkg::LAT_W-1:0]  point_lat,
  input  logic signed [pip_pkg::LON_W-1:0]  point_lon,
  input  pip_pkg::pip_cmd_t                 cmd,
  output pip_pkg::pip_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res
);
  import pip_pkg::*;

  localparam int VTX_W = LAT_W + LON_W;

  logic [VTX_W-1:0]         vtx_mem [MAX_VERTICES];
  logic [VTX_W-1:0]         rd_q;
  logic [VTX_W-1:0]         prev_q;
  logic                     rd_vld;
  logic                     rd_edge_q;
  logic [CNT_W-1:0]         vertex_count;
  logic signed [LAT_W-1:0]  q_lat;
  logic signed [LON_W-1:0]  q_lon;

  logic signed [LAT_W-1:0]  yi, yj;
  logic signed [LON_W-1:0]  xi, xj;
  logic signed [LAT_W:0]    dy, dlat;
  logic signed [LON_W:0]    dlon, dx;
  logic signed [PROD_W-1:0] lhs_next, rhs_next;
  logic                     straddle;

  logic                     s2_vld;
  logic                     s2_edge;
  logic                     s2_dy_pos;
  logic signed [PROD_W-1:0] lhs, rhs;
  logic                     toggle;
  logic                     inside_flag;

  // Vertex count register, saturated on read
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign sts.count    = (vertex_count > CNT_MAX) ? CNT_MAX : vertex_count;
  assign sts.busy     = rd_vld || s2_vld;
  assign sts.out_full = out_valid && !out_ready;

  // Vertex table: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vtx_mem[vertex_index] <= {point_lat, point_lon};
    end
    if (cmd.rd_en) begin
      rd_q <= vtx_mem[cmd.rd_addr];
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_lat <= point_lat;
      q_lon <= point_lon;
    end
  end

  // Read tags and previous vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_edge_q <= 1'b0;
    end else begin
      rd_vld    <= cmd.rd_en;
      rd_edge_q <= cmd.rd_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_q <= rd_q;
    end
  end

  // Edge stage one: differences and cross products
  assign yi = rd_q[VTX_W-1:LON_W];
  assign xi = rd_q[LON_W-1:0];
  assign yj = prev_q[VTX_W-1:LON_W];
  assign xj = prev_q[LON_W-1:0];

  assign dy       = {yj[LAT_W-1], yj} - {yi[LAT_W-1], yi};
  assign dlat     = {q_lat[LAT_W-1], q_lat} - {yi[LAT_W-1], yi};
  assign dlon     = {q_lon[LON_W-1], q_lon} - {xi[LON_W-1], xi};
  assign dx       = {xj[LON_W-1], xj} - {xi[LON_W-1], xi};
  assign lhs_next = dlon * dy;
  assign rhs_next = dx * dlat;
  assign straddle = (yi > q_lat) != (yj > q_lat);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld  <= 1'b0;
      s2_edge <= 1'b0;
    end else begin
      s2_vld  <= rd_vld;
      s2_edge <= rd_vld && rd_edge_q && straddle;
    end
  end

  always_ff @(posedge clk) begin
    lhs       <= lhs_next;
    rhs       <= rhs_next;
    s2_dy_pos <= dy > 0;
  end

  // Edge stage two: compare and flip the inside flag
  assign toggle = s2_edge && (s2_dy_pos ? (lhs < rhs) : (lhs > rhs));

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_flag <= 1'b0;
    end else if (cmd.start) begin
      inside_flag <= 1'b0;
    end else if (toggle) begin
      inside_flag <= !inside_flag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      inside_res <= inside_flag;
    end
  end

  `ASSERT_SAME_CYCLE(a_publish_settled, clk, rst, cmd.publish,
    !rd_vld && !s2_vld, "result published while edges still in flight")
  `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
    "result dropped before it was taken")
  `ASSERT_NEXT_CYCLE(a_out_stable, clk, rst, out_valid && !out_ready,
    $stable(inside_res), "result changed while waiting")

endmodule

// ===== rtl/core/point_in_polygon_test_top.sv =====
// Even-odd ray-casting point-in-polygon test. A load request (action 0)
// writes one vertex into a 32-entry table. A query request (action 1)
// walks the edges of vertices 0 to vertex_count-1, the first edge closing
// back to the last vertex, and returns one inside_res; loads return
// nothing. A query reads its vertices from the single-port vertex table,
// one vertex per cycle, into a two-stage multiply and compare pipeline.
// vertex_count above 32 acts as 32. Every vertex a query uses must have been
// loaded since reset. Write vertex_count only while no request is in flight.
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Top level: controller and datapath of the point-in-polygon test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_test_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pip_pkg::CNT_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [pip_pkg::VIDX_W-1:0]        vertex_index,
  input  logic signed [pip_pkg::LAT_W-1:0]  point_lat,
  input  logic signed [pip_pkg::LON_W-1:0]  point_lon,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res
);
  import pip_pkg::*;

  pip_cmd_t cmd;
  pip_sts_t sts;

  // Sequencer
  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, edge pipeline and output register
  pip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .vertex_index (vertex_index),
    .point_lat    (point_lat),
    .point_lon    (point_lon),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .inside_res   (inside_res)
  );

endmodule

// ===== tb/tb_point_in_polygon_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_top
// Self-checking bench for the point-in-polygon test core. A queue of vertex
// loads and point queries feeds a valid/ready driver. A monitor pairs every
// inside_res with the answer computed here from a local copy of the vertex
// table and the vertex count. Directed corner cases run first: the reset
// count, extreme coordinates, vertex and latitude ties, and counts below
// three. Random polygons then run under changing counts, up to the saturated
// maximum. Both sides stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------

module tb_point_in_polygon_test_top;
  import pip_pkg::*;

  localparam int RANDOM_REQUESTS = 750;
  localparam int QUIET_CYCLES    = 48;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic                    action;
    logic [VIDX_W-1:0]       index;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } pip_req_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_wr_en    = 1'b0;
  logic [CNT_W-1:0]        cfg_wr_data  = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    action       = ACT_LOAD;
  logic [VIDX_W-1:0]       vertex_index = '0;
  logic signed [LAT_W-1:0] point_lat    = '0;
  logic signed [LON_W-1:0] point_lon    = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic                    inside_res;

  point_in_polygon_test_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .vertex_index (vertex_index),
    .point_lat    (point_lat),
    .point_lon    (point_lon),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .inside_res   (inside_res)
  );

  // Pending requests, expected answers and the local polygon state
  pip_req_t                pending_reqs[$];
  bit                      expected_inside[$];
  logic signed [LAT_W-1:0] vtx_lat [MAX_VERTICES];
  logic signed [LON_W-1:0] vtx_lon [MAX_VERTICES];
  logic [CNT_W-1:0]        vertex_count_model = CNT_RESET;

  bit       steady = 1'b0;
  int       mismatches = 0;
  int       cycles = 0;
  int       queued_reqs = 0;
  pip_req_t next_req;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Does edge (i, j) flip the inside flag for the point (lat, lon)?
  function automatic bit edge_flips(longint yi, longint xi, longint yj, longint xj,
                                    longint lat, longint lon);
    longint dy, lhs, rhs;
    if ((yi > lat) == (yj > lat))
      return 1'b0;
    dy  = yj - yi;
    lhs = (lon - xi) * dy;
    rhs = (xj - xi) * (lat - yi);
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Walk all edges of the polygon in use, the first closing to the last vertex
  function automatic bit point_inside(longint lat, longint lon);
    int n, j;
    bit inside_flag;
    n = (vertex_count_model > CNT_MAX) ? MAX_VERTICES : int'(vertex_count_model);
    inside_flag = 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if (edge_flips(vtx_lat[i], vtx_lon[i], vtx_lat[j], vtx_lon[j], lat, lon))
        inside_flag = !inside_flag;
      j = i;
    end
    return inside_flag;
  endfunction

  // Update the table on a load, queue the answer on a query
  function automatic void track_request(pip_req_t r);
    if (r.action == ACT_LOAD) begin
      vtx_lat[r.index] = r.lat;
      vtx_lon[r.index] = r.lon;
    end else begin
      expected_inside.push_back(point_inside(r.lat, r.lon));
    end
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s", $time, msg);
  endfunction

  function automatic void queue_request(logic act, int idx, int lat, int lon);
    pending_reqs.push_back(pip_req_t'{act, VIDX_W'(idx), LAT_W'(lat), LON_W'(lon)});
    queued_reqs++;
  endfunction

  function automatic int spread(int r);
    int v;
    v = $urandom_range(2 * r);
    return v - r;
  endfunction

  function automatic int any_lat();
    logic signed [LAT_W-1:0] v;
    v = LAT_W'($urandom);
    return v;
  endfunction

  function automatic int any_lon();
    logic signed [LON_W-1:0] v;
    v = LON_W'($urandom);
    return v;
  endfunction

  // Mostly small polygons, now and then the full table or a saturated count
  function automatic int pick_count();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return MAX_VERTICES;
      4:       return (1 << CNT_W) - 1;
      5:       return $urandom_range(MAX_VERTICES + 1, (1 << CNT_W) - 2);
      6, 7:    return $urandom_range(11, MAX_VERTICES - 1);
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  // Wait until every request is taken and answered, then let the core settle
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_inside.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(int value);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    vertex_count_model = CNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // One polygon: set the count, load its vertices, then probe it
  task automatic run_phase(int count_value);
    int n, c_lat, c_lon, rad, per, pos, pct, n_queries, pick, k;
    int lat_a, lon_a;
    bit scatter, is_query;
    int vl [MAX_VERTICES];
    int vo [MAX_VERTICES];
    set_vertex_count(count_value);
    n       = (count_value > MAX_VERTICES) ? MAX_VERTICES : count_value;
    rad     = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(200, 3000);
    c_lat   = $urandom_range(40000) - 20000;
    c_lon   = $urandom_range(80000) - 40000;
    scatter = ($urandom_range(4) == 0);
    per     = 8 * rad;

    // Vertices around a jittered square, or scattered in its box and now and then anywhere
    for (int i = 0; i < n; i++) begin
      pos = (i * per) / n;
      if (pos < 2 * rad) begin
        lat_a = -rad + pos;            lon_a = -rad;
      end else if (pos < 4 * rad) begin
        lat_a = rad;                   lon_a = -rad + (pos - 2 * rad);
      end else if (pos < 6 * rad) begin
        lat_a = rad - (pos - 4 * rad); lon_a = rad;
      end else begin
        lat_a = -rad;                  lon_a = rad - (pos - 6 * rad);
      end
      pct = $urandom_range(30, 100);
      if (scatter && $urandom_range(7) == 0) begin
        vl[i] = any_lat();
        vo[i] = any_lon();
      end else if (scatter) begin
        vl[i] = c_lat + spread(rad);
        vo[i] = c_lon + spread(rad);
      end else begin
        vl[i] = c_lat + lat_a * pct / 100;
        vo[i] = c_lon + lon_a * pct / 100;
      end
      queue_request(ACT_LOAD, i, vl[i], vo[i]);
    end

    // Queries, with a few vertex rewrites mixed in
    n_queries = $urandom_range(10, 22);
    for (int q = 0; q < n_queries; q++) begin
      pick     = $urandom_range(99);
      is_query = 1'b1;
      if (n > 0 && pick < 20) begin
        k     = $urandom_range(n - 1);
        lat_a = vl[k];
        lon_a = c_lon + spread(2 * rad);
      end else if (n > 0 && pick < 32) begin
        k     = $urandom_range(n - 1);
        lat_a = vl[k];
        lon_a = vo[k];
      end else if (pick < 42) begin
        lat_a = any_lat();
        lon_a = any_lon();
      end else if (pick < 47) begin
        is_query = 1'b0;
        k     = $urandom_range(MAX_VERTICES - 1);
        lat_a = c_lat + spread(rad);
        lon_a = c_lon + spread(rad);
        if (k < n) begin
          vl[k] = lat_a;
          vo[k] = lon_a;
        end
        queue_request(ACT_LOAD, k, lat_a, lon_a);
      end else begin
        lat_a = c_lat + spread(rad + rad / 4);
        lon_a = c_lon + spread(rad + rad / 4);
      end
      if (is_query)
        queue_request(ACT_QUERY, $urandom_range(MAX_VERTICES - 1), lat_a, lon_a);
    end
  endtask

  // Driver: hold a request until taken, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        track_request(pip_req_t'{action, vertex_index, point_lat, point_lon});
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 12)) begin
          next_req     = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          action       <= next_req.action;
          vertex_index <= next_req.index;
          point_lat    <= next_req.lat;
          point_lon    <= next_req.lon;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each answer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_inside.size() == 0)
          flag_error($sformatf("inside_res %0b with no query outstanding", inside_res));
        else if (inside_res !== expected_inside[0])
          flag_error($sformatf("inside_res: expected %0b, got %0b",
                               expected_inside[0], inside_res));
        if (expected_inside.size() != 0)
          void'(expected_inside.pop_front());
      end
      out_ready <= steady || ($urandom_range(99) >= 12);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int directed_reqs, phase_no;
    phase_no = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset count of three: a small triangle, ties on vertices and latitudes
    queue_request(ACT_LOAD, 0, -1000, -1000);
    queue_request(ACT_LOAD, 1, 1000, 0);
    queue_request(ACT_LOAD, 2, -1000, 1000);
    queue_request(ACT_QUERY, 0, 0, 0);
    queue_request(ACT_QUERY, 31, 0, 5000);
    queue_request(ACT_QUERY, 0, -1000, 0);
    queue_request(ACT_QUERY, 0, 1000, 0);
    queue_request(ACT_QUERY, 0, -1000, -1000);

    // Extreme coordinates
    queue_request(ACT_LOAD, 0, -32768, -65536);
    queue_request(ACT_LOAD, 1, 32767, 0);
    queue_request(ACT_LOAD, 2, -32768, 65535);
    queue_request(ACT_LOAD, 31, 32767, -65536);
    queue_request(ACT_QUERY, 0, 0, 0);
    queue_request(ACT_QUERY, 0, 32767, 65535);
    queue_request(ACT_QUERY, 0, -32768, -65536);
    queue_request(ACT_QUERY, 0, 0, -65536);

    // Counts below three never enclose a point
    set_vertex_count(0);
    queue_request(ACT_QUERY, 0, 0, 0);
    set_vertex_count(1);
    queue_request(ACT_QUERY, 0, 0, 0);
    set_vertex_count(2);
    queue_request(ACT_QUERY, 0, 0, -100);
    directed_reqs = queued_reqs;

    // Random polygons: saturated and full counts first, then a mix
    run_phase((1 << CNT_W) - 1);
    run_phase(MAX_VERTICES);
    while (queued_reqs < directed_reqs + RANDOM_REQUESTS) begin
      phase_no++;
      steady = (phase_no >= 4 && phase_no < 9);
      run_phase(pick_count());
    end
    steady = 1'b0;

    wait_quiet();
    if (mismatches == 0 && expected_inside.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
